// ===== design/sra_pkg.sv =====
package sra_pkg;

   // request channel command codes
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_RX    = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   // register kinds
   localparam logic [1:0] KIND_RELAY  = 2'd0;
   localparam logic [1:0] KIND_INPUT  = 2'd1;
   localparam logic [1:0] KIND_PARAM  = 2'd2;
   localparam logic [1:0] KIND_BRIGHT = 2'd3;

   // frame bytes
   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] OP_READ   = 8'h05;
   localparam logic [7:0] OP_WRITE  = 8'h06;
   localparam logic [7:0] OP_BRIGHT = 8'h0A;
   localparam logic [7:0] RELAY_ON  = 8'd255;

   // result kinds
   localparam logic RSP_TX     = 1'b0;
   localparam logic RSP_REPORT = 1'b1;

   // completion status
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_CHECKSUM = 3'd1;
   localparam logic [2:0] ST_COMMAND  = 3'd2;
   localparam logic [2:0] ST_MODULE   = 3'd3;
   localparam logic [2:0] ST_INDEX    = 3'd4;
   localparam logic [2:0] ST_VALUE    = 3'd5;

   // what the parser must see echoed back
   typedef struct packed {
      logic [7:0] command;
      logic [7:0] index;
      logic [1:0] reg_kind;
      logic [7:0] value;
      logic       is_write;
   } expect_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] status;
      logic [7:0] read_value;
   } report_type;

endpackage

// ===== design/sra_channels.sv =====
interface sra_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [1:0]  reg_kind;
   logic [7:0]  slave_id;
   logic [15:0] reg_address;
   logic [7:0]  write_value;
   logic [7:0]  rx_byte;

   modport source (output valid, cmd, reg_kind, slave_id, reg_address, write_value, rx_byte,
                   input ready);
   modport sink (input valid, cmd, reg_kind, slave_id, reg_address, write_value, rx_byte,
                 output ready);
endinterface

interface sra_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] tx_byte;
   logic       tx_last;
   logic [2:0] status;
   logic [7:0] read_value;

   modport source (output valid, kind, tx_byte, tx_last, status, read_value, input ready);
   modport sink (input valid, kind, tx_byte, tx_last, status, read_value, output ready);
endinterface

// ===== design/sra_rx_parser.sv =====
module sra_rx_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  sra_pkg::expect_type start_info,
   input  logic                rx_valid,
   input  logic [7:0]          rx_byte,
   output sra_pkg::report_type report
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_SYNC1   = 3'd1;
   localparam logic [2:0] PH_SYNC2   = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CSUM    = 3'd4;
   localparam logic [2:0] PAY_LAST   = 3'd4;

   logic [2:0]          phase_ff, phase_in;
   logic [2:0]          count_ff, count_in;
   logic [7:0]          sum_ff, sum_in;
   sra_pkg::expect_type exp_ff, exp_in;
   logic [7:0]          payload_ff [5];
   logic [2:0]          status;

   // first failing check wins
   always_comb begin
      if (rx_byte != sum_ff) begin
         status = sra_pkg::ST_CHECKSUM;
      end else if (payload_ff[0] != exp_ff.command) begin
         status = sra_pkg::ST_COMMAND;
      end else if (payload_ff[1] != 8'd0) begin
         status = sra_pkg::ST_MODULE;
      end else if (payload_ff[3] != exp_ff.index) begin
         status = sra_pkg::ST_INDEX;
      end else if (exp_ff.is_write && payload_ff[2] != exp_ff.value) begin
         status = sra_pkg::ST_VALUE;
      end else begin
         status = sra_pkg::ST_OK;
      end
   end

   always_comb begin
      report.valid      = rx_valid && phase_ff == PH_CSUM;
      report.status     = status;
      report.read_value = 8'd0;
      if (status == sra_pkg::ST_OK && !exp_ff.is_write) begin
         if (exp_ff.reg_kind == sra_pkg::KIND_RELAY) begin
            report.read_value = {7'd0, payload_ff[2] != 8'd0};
         end else begin
            report.read_value = payload_ff[2];
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      exp_in   = exp_ff;
      if (start) begin
         exp_in   = start_info;
         sum_in   = 8'd0;
         count_in = 3'd0;
         phase_in = PH_SYNC1;
      end else if (rx_valid) begin
         case (phase_ff)
            PH_SYNC1: begin
               if (rx_byte == sra_pkg::SYNC_BYTE) phase_in = PH_SYNC2;
            end
            PH_SYNC2: begin
               phase_in = (rx_byte == sra_pkg::SYNC_BYTE) ? PH_PAYLOAD : PH_SYNC1;
               sum_in   = 8'd0;
               count_in = 3'd0;
            end
            PH_PAYLOAD: begin
               sum_in   = sum_ff + rx_byte;
               count_in = count_ff + 3'd1;
               if (count_ff == PAY_LAST) phase_in = PH_CSUM;
            end
            PH_CSUM: begin
               phase_in = PH_IDLE;
               sum_in   = 8'd0;
               count_in = 3'd0;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= 3'd0;
         sum_ff   <= 8'd0;
         exp_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         exp_ff   <= exp_in;
      end
   end

   // payload bytes hold no reset; each is written before the checksum phase reads it
   always_ff @(posedge clock) begin
      if (!start && rx_valid && phase_ff == PH_PAYLOAD) begin
         payload_ff[count_ff] <= rx_byte;
      end
   end

endmodule

// ===== design/serial_register_access_engine.sv =====
// Channel | Dir | Transfer
// req_ch  | in  | start read / start write / received line byte
// rsp_ch  | out | frame byte to send, or completion report
//
// A received byte updates the parser state at the transfer, and a report, if any,
// lands in the output register at the same edge.
// A start loads byte 0 at the transfer; the frame sequencer then feeds one byte per
// cycle while the slot is free; req_ch holds off until the eighth byte is loaded.
// Stalls on rsp_ch hold the output register and back up into req_ch.
// Reset is synchronous: parser idle, output register empty, no frame in flight.
module serial_register_access_engine (
   input logic      clock,
   input logic      reset,
   sra_req_if.sink  req_ch,
   sra_rsp_if.source rsp_ch
);

   // handshake
   logic slot_free;
   logic req_fire;
   logic is_start;
   logic is_rx;

   // request frame fields
   sra_pkg::expect_type start_info;
   logic [7:0]          req_sum;

   // frame sequencer
   logic       frame_active_ff, frame_active_in;
   logic [2:0] tx_count_ff, tx_count_in;
   logic [7:0] fr_op_ff, fr_slave_ff, fr_val_ff, fr_idx_ff, fr_sum_ff;
   logic [7:0] frame_byte;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_tx_byte_ff, rsp_tx_byte_in;
   logic       rsp_tx_last_ff, rsp_tx_last_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_read_value_ff, rsp_read_value_in;

   sra_pkg::report_type report;

   // Output slot can take a new result when empty or being drained this cycle.
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !reset && !frame_active_ff && slot_free;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_start     = req_fire &&
                         (req_ch.cmd == sra_pkg::CMD_READ || req_ch.cmd == sra_pkg::CMD_WRITE);
   assign is_rx        = req_fire && req_ch.cmd == sra_pkg::CMD_RX;

   // Build the request: brightness writes index by the address high byte,
   // relay writes collapse any nonzero value to full on.
   always_comb begin
      start_info.reg_kind = req_ch.reg_kind;
      start_info.is_write = req_ch.cmd == sra_pkg::CMD_WRITE;
      if (start_info.is_write) begin
         if (req_ch.reg_kind == sra_pkg::KIND_BRIGHT) begin
            start_info.command = sra_pkg::OP_BRIGHT;
            start_info.index   = req_ch.reg_address[15:8];
         end else begin
            start_info.command = sra_pkg::OP_WRITE;
            start_info.index   = req_ch.reg_address[7:0];
         end
         if (req_ch.reg_kind == sra_pkg::KIND_RELAY && req_ch.write_value != 8'd0) begin
            start_info.value = sra_pkg::RELAY_ON;
         end else begin
            start_info.value = req_ch.write_value;
         end
      end else begin
         start_info.command = sra_pkg::OP_READ;
         start_info.index   = req_ch.reg_address[7:0];
         start_info.value   = 8'd0;
      end
   end

   // checksum over command, slave, value, index (the trailing zero adds nothing)
   assign req_sum = start_info.command + req_ch.slave_id + start_info.value + start_info.index;

   sra_rx_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .start      (is_start),
      .start_info (start_info),
      .rx_valid   (is_rx),
      .rx_byte    (req_ch.rx_byte),
      .report     (report)
   );

   // byte 0 goes out at the start transfer; the sequencer walks bytes 1..7
   always_comb begin
      case (tx_count_ff)
         3'd1:    frame_byte = sra_pkg::SYNC_BYTE;
         3'd2:    frame_byte = fr_op_ff;
         3'd3:    frame_byte = fr_slave_ff;
         3'd4:    frame_byte = fr_val_ff;
         3'd5:    frame_byte = fr_idx_ff;
         3'd6:    frame_byte = 8'd0;
         3'd7:    frame_byte = fr_sum_ff;
         default: frame_byte = sra_pkg::SYNC_BYTE;
      endcase
   end

   always_comb begin
      frame_active_in   = frame_active_ff;
      tx_count_in       = tx_count_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_kind_in       = rsp_kind_ff;
      rsp_tx_byte_in    = rsp_tx_byte_ff;
      rsp_tx_last_in    = rsp_tx_last_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_read_value_in = rsp_read_value_ff;
      if (is_start) begin
         frame_active_in   = 1'b1;
         tx_count_in       = 3'd1;
         rsp_valid_in      = 1'b1;
         rsp_kind_in       = sra_pkg::RSP_TX;
         rsp_tx_byte_in    = sra_pkg::SYNC_BYTE;
         rsp_tx_last_in    = 1'b0;
         rsp_status_in     = sra_pkg::ST_OK;
         rsp_read_value_in = 8'd0;
      end else if (report.valid) begin
         rsp_valid_in      = 1'b1;
         rsp_kind_in       = sra_pkg::RSP_REPORT;
         rsp_tx_byte_in    = 8'd0;
         rsp_tx_last_in    = 1'b0;
         rsp_status_in     = report.status;
         rsp_read_value_in = report.read_value;
      end else if (frame_active_ff && slot_free) begin
         rsp_valid_in      = 1'b1;
         rsp_kind_in       = sra_pkg::RSP_TX;
         rsp_tx_byte_in    = frame_byte;
         rsp_tx_last_in    = tx_count_ff == 3'd7;
         rsp_status_in     = sra_pkg::ST_OK;
         rsp_read_value_in = 8'd0;
         tx_count_in       = tx_count_ff + 3'd1;
         if (tx_count_ff == 3'd7) frame_active_in = 1'b0;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff <= 1'b0;
         tx_count_ff     <= 3'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_active_ff <= frame_active_in;
         tx_count_ff     <= tx_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      rsp_kind_ff       <= rsp_kind_in;
      rsp_tx_byte_ff    <= rsp_tx_byte_in;
      rsp_tx_last_ff    <= rsp_tx_last_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_read_value_ff <= rsp_read_value_in;
      if (is_start) begin
         fr_op_ff    <= start_info.command;
         fr_slave_ff <= req_ch.slave_id;
         fr_val_ff   <= start_info.value;
         fr_idx_ff   <= start_info.index;
         fr_sum_ff   <= req_sum;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = rsp_kind_ff;
   assign rsp_ch.tx_byte    = rsp_tx_byte_ff;
   assign rsp_ch.tx_last    = rsp_tx_last_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.read_value = rsp_read_value_ff;

   // a frame in flight always has a byte waiting in the output register
   a_frame_has_byte: assert property (@(posedge clock) disable iff (reset)
      frame_active_ff |-> rsp_valid_ff)
      else $error("frame in flight with empty output register");

   // the last frame byte is only shown once the sequencer has finished
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tx_last_ff) |-> !frame_active_ff)
      else $error("last frame byte while sequencer still running");

   // a start transfer puts a sync byte in the output register at the next edge
   a_start_sync: assert property (@(posedge clock) disable iff (reset)
      is_start |=> (rsp_valid_ff && rsp_kind_ff == sra_pkg::RSP_TX &&
                    rsp_tx_byte_ff == sra_pkg::SYNC_BYTE && frame_active_ff))
      else $error("start transfer did not open a frame");

   // reports never carry frame fields
   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == sra_pkg::RSP_REPORT) |->
         (rsp_tx_byte_ff == 8'd0 && !rsp_tx_last_ff && !frame_active_ff))
      else $error("report overlaps a frame");

endmodule

// ===== sim/sra_checker.sv =====
module sra_checker
   import sra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sra_req_if          req_ch,
   sra_rsp_if          rsp_ch,
   output int unsigned mismatch_count,
   output int unsigned due_count,
   output int unsigned reports_checked,
   output logic [5:0]  status_seen
);

   typedef enum logic [2:0] {
      LINE_IDLE,
      LINE_SYNC1,
      LINE_SYNC2,
      LINE_PAYLOAD,
      LINE_CSUM
   } line_phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] tx_byte;
      logic       tx_last;
      logic [2:0] status;
      logic [7:0] read_value;
   } rsp_beat_type;

   rsp_beat_type   due_q[$];

   // parser shadow
   line_phase_type line_phase;
   logic [7:0]  echo_buf [5];
   logic [7:0]  echo_sum;
   int unsigned echo_count;

   // what the pending access must see echoed
   logic [7:0]  want_cmd;
   logic [7:0]  want_idx;
   logic [7:0]  want_val;
   logic [1:0]  want_kind;
   logic        want_write;

   task automatic frame_out(input logic write_op, input logic [1:0] rk, input logic [7:0] slave,
                            input logic [15:0] addr, input logic [7:0] wval);
      logic [7:0] op;
      logic [7:0] idx;
      logic [7:0] val;
      logic [7:0] csum;
      logic [7:0] frame [8];
      int unsigned i;
      if (write_op) begin
         op  = (rk == KIND_BRIGHT) ? OP_BRIGHT : OP_WRITE;
         idx = (rk == KIND_BRIGHT) ? addr[15:8] : addr[7:0];
         val = (rk == KIND_RELAY && wval != 8'd0) ? RELAY_ON : wval;
      end else begin
         op  = OP_READ;
         idx = addr[7:0];
         val = 8'd0;
      end
      csum  = op + slave + val + idx;
      frame = '{SYNC_BYTE, SYNC_BYTE, op, slave, val, idx, 8'd0, csum};
      for (i = 0; i < 8; i++)
         due_q.push_back('{RSP_TX, frame[i[2:0]], (i == 7), ST_OK, 8'd0});
      // a new start drops whatever reply was in progress
      want_cmd   = op;
      want_idx   = idx;
      want_val   = val;
      want_kind  = rk;
      want_write = write_op;
      echo_sum   = 8'd0;
      echo_count = 0;
      line_phase = LINE_SYNC1;
   endtask

   task automatic parse_line(input logic [7:0] b);
      logic [2:0] st;
      logic [7:0] rv;
      st = ST_OK;
      rv = 8'd0;
      case (line_phase)
         LINE_SYNC1: begin
            if (b == SYNC_BYTE)
               line_phase = LINE_SYNC2;
         end
         LINE_SYNC2: begin
            if (b == SYNC_BYTE)
               line_phase = LINE_PAYLOAD;
            else
               line_phase = LINE_SYNC1;
            echo_sum   = 8'd0;
            echo_count = 0;
         end
         LINE_PAYLOAD: begin
            echo_buf[echo_count[2:0]] = b;
            echo_sum                  = echo_sum + b;
            echo_count++;
            if (echo_count == 5)
               line_phase = LINE_CSUM;
         end
         LINE_CSUM: begin
            if (b != echo_sum)
               st = ST_CHECKSUM;
            else if (echo_buf[0] != want_cmd)
               st = ST_COMMAND;
            else if (echo_buf[1] != 8'd0)
               st = ST_MODULE;
            else if (echo_buf[3] != want_idx)
               st = ST_INDEX;
            else if (want_write && echo_buf[2] != want_val)
               st = ST_VALUE;
            if (st == ST_OK && !want_write) begin
               if (want_kind == KIND_RELAY)
                  rv = {7'd0, echo_buf[2] != 8'd0};
               else
                  rv = echo_buf[2];
            end
            due_q.push_back('{RSP_REPORT, 8'd0, 1'b0, st, rv});
            line_phase = LINE_IDLE;
            echo_sum   = 8'd0;
            echo_count = 0;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      if (reset) begin
         due_q.delete();
         line_phase      = LINE_IDLE;
         echo_sum        = 8'd0;
         echo_count      = 0;
         want_cmd        = 8'd0;
         want_idx        = 8'd0;
         want_val        = 8'd0;
         want_kind       = 2'd0;
         want_write      = 1'b0;
         mismatch_count  = 0;
         reports_checked = 0;
         status_seen     = 6'd0;
      end else begin
         // results first: nothing accepted at this edge can already be out
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.kind, rsp_ch.tx_byte, rsp_ch.tx_last, rsp_ch.status,
                    rsp_ch.read_value};
            if (due_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: rsp transfer with none due: kind=%0d tx_byte=%02h tx_last=%0d status=%0d read_value=%02h",
                           $time, got.kind, got.tx_byte, got.tx_last, got.status,
                           got.read_value);
               mismatch_count++;
            end else begin
               want = due_q.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display("%0t: rsp mismatch: expected kind=%0d tx_byte=%02h tx_last=%0d status=%0d read_value=%02h, got kind=%0d tx_byte=%02h tx_last=%0d status=%0d read_value=%02h",
                              $time, want.kind, want.tx_byte, want.tx_last, want.status,
                              want.read_value, got.kind, got.tx_byte, got.tx_last,
                              got.status, got.read_value);
                  mismatch_count++;
               end
               if (want.kind == RSP_REPORT) begin
                  reports_checked++;
                  if (want.status <= ST_VALUE)
                     status_seen[want.status] = 1'b1;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.cmd)
               CMD_READ:  frame_out(1'b0, req_ch.reg_kind, req_ch.slave_id, req_ch.reg_address,
                                    req_ch.write_value);
               CMD_WRITE: frame_out(1'b1, req_ch.reg_kind, req_ch.slave_id, req_ch.reg_address,
                                    req_ch.write_value);
               CMD_RX:    parse_line(req_ch.rx_byte);
               default: ;
            endcase
         end
      end
      due_count <= due_q.size();
   end

endmodule

// ===== sim/testbench.sv =====
module testbench;
   import sra_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 32;
   localparam int unsigned STALL_LIMIT  = 1000;  // cycles with no transfer on either side
   localparam int unsigned HOLD_CYCLES  = 80;    // long receiver hold-off
   localparam int unsigned CLEAN_CYCLES = 100;   // receiver stall-free stretch after it
   localparam int unsigned DRAIN_CYCLES = 16;    // slack once nothing is due any more

   // reply corruption flags, may be combined
   localparam logic [4:0] F_NONE   = 5'b00000;
   localparam logic [4:0] F_SUM    = 5'b00001;
   localparam logic [4:0] F_CMD    = 5'b00010;
   localparam logic [4:0] F_MODULE = 5'b00100;
   localparam logic [4:0] F_INDEX  = 5'b01000;
   localparam logic [4:0] F_VALUE  = 5'b10000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sra_req_if req_ch ();
   sra_rsp_if rsp_ch ();

   serial_register_access_engine i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   int unsigned mismatch_count;
   int unsigned due_count;
   int unsigned reports_checked;
   logic [5:0]  status_seen;

   sra_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .mismatch_count  (mismatch_count),
      .due_count       (due_count),
      .reports_checked (reports_checked),
      .status_seen     (status_seen)
   );

   always #6 clock = ~clock;

   // req transfer seen at the last rising edge; read by the driver at the falling edge
   logic req_took = 1'b0;
   always @(posedge clock) req_took <= req_ch.valid && req_ch.ready;

   // watchdog: no transfer on either channel for too long means a hang
   int unsigned quiet_run = 0;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_run <= 0;
      end else if (quiet_run >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("serial_register_access_engine verification failed");
         $finish;
      end else begin
         quiet_run <= quiet_run + 1;
      end
   end

   // stimulus bookkeeping
   bit          flood_go    = 1'b0;  // random part running, receiver may choke now
   bit          steady_send = 1'b0;  // sender gaps off
   int unsigned counted_items = 0;   // starts and line bytes; NOPs do not count
   int unsigned starts_sent = 0;
   int unsigned line_bytes_sent = 0;

   // frame fields of the last start, used to build a matching reply
   logic [7:0] sent_op;
   logic [7:0] sent_idx;
   logic [7:0] sent_val;
   logic       sent_write;

   // Receiver: random ready with one long hold-off once the random part starts,
   // followed by a stall-free stretch.
   initial begin
      int unsigned hold_left;
      int unsigned clean_left;
      bit          held;
      hold_left    = 0;
      clean_left   = 0;
      held         = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
            if (hold_left == 0)
               clean_left = CLEAN_CYCLES;
         end else if (flood_go && !held) begin
            // sender keeps offering; the output register and frame sequencer back up
            held         = 1'b1;
            hold_left    = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else if (clean_left > 0) begin
            rsp_ch.ready <= 1'b1;
            clean_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 12);
         end
      end
   end

   // One req transfer. Called at a falling edge, returns at the falling edge
   // after the transfer, so back-to-back items keep valid high without a glitch.
   task automatic offer(input logic [1:0] c, input logic [1:0] rk, input logic [7:0] slave,
                        input logic [15:0] addr, input logic [7:0] wval, input logic [7:0] rxb);
      if (!steady_send && $urandom_range(99) < 12) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= c;
      req_ch.reg_kind    <= rk;
      req_ch.slave_id    <= slave;
      req_ch.reg_address <= addr;
      req_ch.write_value <= wval;
      req_ch.rx_byte     <= rxb;
      do
         @(negedge clock);
      while (!req_took);
      if (c != CMD_NOP)
         counted_items++;
   endtask

   // received line byte; the other fields carry random junk
   task automatic line_byte(input logic [7:0] b);
      offer(CMD_RX, 2'($urandom_range(3)), 8'($urandom_range(255)), 16'($urandom_range(65535)),
            8'($urandom_range(255)), b);
      line_bytes_sent++;
   endtask

   task automatic pass_nop();
      offer(CMD_NOP, 2'($urandom_range(3)), 8'($urandom_range(255)), 16'($urandom_range(65535)),
            8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   task automatic begin_access(input logic write_op, input logic [1:0] rk, input logic [7:0] slave,
                               input logic [15:0] addr, input logic [7:0] wval);
      // remember what goes on the line so a reply can echo it
      if (write_op) begin
         sent_op  = (rk == KIND_BRIGHT) ? OP_BRIGHT : OP_WRITE;
         sent_idx = (rk == KIND_BRIGHT) ? addr[15:8] : addr[7:0];
         sent_val = (rk == KIND_RELAY && wval != 8'd0) ? RELAY_ON : wval;
      end else begin
         sent_op  = OP_READ;
         sent_idx = addr[7:0];
         sent_val = 8'd0;
      end
      sent_write = write_op;
      offer(write_op ? CMD_WRITE : CMD_READ, rk, slave, addr, wval, 8'($urandom_range(255)));
      starts_sent++;
   endtask

   // Slave reply to the last start. noise > 0 puts that many non-sync bytes
   // ahead, then a lone sync byte and a non-sync byte (second-sync fallback).
   // Only the first `cut` of the 8 reply bytes go out.
   task automatic answer(input logic [4:0] faults, input logic [7:0] rd_val,
                         input int unsigned noise, input int unsigned cut);
      logic [7:0]  p [5];
      logic [7:0]  reply [8];
      logic [7:0]  csum;
      logic [7:0]  flip;
      int unsigned i;
      p[0] = sent_op;
      p[1] = 8'd0;
      p[2] = sent_write ? sent_val : rd_val;
      p[3] = sent_idx;
      p[4] = 8'($urandom_range(255));
      flip = 8'($urandom_range(1, 255));
      if (faults & F_CMD)    p[0] = p[0] ^ flip;
      if (faults & F_MODULE) p[1] = 8'($urandom_range(1, 255));
      if (faults & F_INDEX)  p[3] = p[3] ^ flip;
      if (faults & F_VALUE)  p[2] = p[2] ^ flip;
      csum = p[0] + p[1] + p[2] + p[3] + p[4];
      if (faults & F_SUM)
         csum = csum + 8'($urandom_range(1, 255));
      reply = '{SYNC_BYTE, SYNC_BYTE, p[0], p[1], p[2], p[3], p[4], csum};
      if (noise > 0) begin
         repeat (noise) line_byte(8'($urandom_range(254)));
         line_byte(SYNC_BYTE);
         line_byte(8'($urandom_range(254)));
      end
      for (i = 0; i < cut && i < 8; i++) begin
         if ($urandom_range(99) < 5)
            pass_nop();
         line_byte(reply[i[2:0]]);
      end
   endtask

   initial begin
      int unsigned random_first;
      int unsigned pick;
      int unsigned cut;
      logic [4:0]  faults;
      logic [7:0]  wv;
      logic [7:0]  rv;

      req_ch.valid       = 1'b0;
      req_ch.cmd         = CMD_NOP;
      req_ch.reg_kind    = KIND_RELAY;
      req_ch.slave_id    = 8'd0;
      req_ch.reg_address = 16'd0;
      req_ch.write_value = 8'd0;
      req_ch.rx_byte     = 8'd0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // line byte with no access pending, and a NOP: both ignored
      line_byte(SYNC_BYTE);
      pass_nop();
      // reads at the field extremes; relay reads fold to 0/1
      begin_access(1'b0, KIND_RELAY, 8'd0, 16'h0000, 8'd0);
      answer(F_NONE, 8'd0, 0, 8);
      begin_access(1'b0, KIND_RELAY, 8'hFF, 16'hFFFF, 8'hFF);
      answer(F_NONE, 8'h80, 0, 8);
      begin_access(1'b0, KIND_INPUT, 8'h5A, 16'h12AB, 8'h00);
      answer(F_NONE, 8'hFF, 0, 8);
      // resync: junk before the first sync, then a broken sync pair
      begin_access(1'b0, KIND_PARAM, 8'hA5, 16'hFF00, 8'h33);
      answer(F_NONE, 8'h5A, 2, 8);
      // writes: relay zero, relay nonzero forced to 255, param, brightness high byte
      begin_access(1'b1, KIND_RELAY, 8'h01, 16'h0001, 8'h00);
      answer(F_NONE, 8'd0, 0, 8);
      begin_access(1'b1, KIND_RELAY, 8'h7F, 16'h8001, 8'h37);
      answer(F_NONE, 8'd0, 0, 8);
      begin_access(1'b1, KIND_PARAM, 8'hFF, 16'hFFFF, 8'hFF);
      answer(F_NONE, 8'd0, 0, 8);
      begin_access(1'b1, KIND_BRIGHT, 8'h10, 16'hAB12, 8'h80);
      answer(F_NONE, 8'd0, 0, 8);
      begin_access(1'b1, KIND_INPUT, 8'h22, 16'h00FE, 8'h00);
      answer(F_NONE, 8'd0, 0, 8);
      // each error status alone
      begin_access(1'b0, KIND_PARAM, 8'h03, 16'h0102, 8'h00);
      answer(F_SUM, 8'h44, 0, 8);
      begin_access(1'b0, KIND_PARAM, 8'h04, 16'h0304, 8'h00);
      answer(F_CMD, 8'h44, 0, 8);
      begin_access(1'b0, KIND_INPUT, 8'h05, 16'h0506, 8'h00);
      answer(F_MODULE, 8'h44, 0, 8);
      begin_access(1'b0, KIND_RELAY, 8'h06, 16'h0708, 8'h00);
      answer(F_INDEX, 8'h01, 0, 8);
      begin_access(1'b1, KIND_PARAM, 8'h07, 16'h090A, 8'h99);
      answer(F_VALUE, 8'd0, 0, 8);
      // check order: first failing check wins
      begin_access(1'b1, KIND_BRIGHT, 8'h08, 16'h0B0C, 8'h11);
      answer(F_CMD | F_MODULE | F_INDEX | F_VALUE, 8'd0, 0, 8);
      begin_access(1'b1, KIND_PARAM, 8'h09, 16'h0D0E, 8'h22);
      answer(F_MODULE | F_VALUE, 8'd0, 0, 8);
      // start while busy: abandon mid-payload and while awaiting the checksum
      begin_access(1'b0, KIND_PARAM, 8'h0A, 16'h0F10, 8'h00);
      answer(F_NONE, 8'h12, 0, 4);
      begin_access(1'b1, KIND_RELAY, 8'h0B, 16'h1112, 8'h01);
      answer(F_NONE, 8'd0, 0, 7);
      begin_access(1'b0, KIND_INPUT, 8'h0C, 16'h1314, 8'h00);
      answer(F_NONE, 8'hC3, 0, 8);
      // stray byte after the report
      line_byte(8'h00);

      // ---- random part ----
      random_first = counted_items;
      flood_go     = 1'b1;
      while (counted_items < random_first + RANDOM_ITEMS) begin
         steady_send = (counted_items >= random_first + 8) &&
                       (counted_items < random_first + 24);
         pick   = $urandom_range(99);
         wv     = ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(255));
         rv     = ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(255));
         faults = ($urandom_range(99) < 60) ? F_NONE : 5'($urandom_range(1, 31));
         if (pick < 75) begin
            // well-formed access with random content, sometimes corrupted or cut short
            begin_access(1'($urandom_range(1)), 2'($urandom_range(3)), 8'($urandom_range(255)),
                         16'($urandom_range(65535)), wv);
            cut = ($urandom_range(99) < 8) ? $urandom_range(7) : 8;
            answer(faults, rv, ($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0, cut);
         end else if (pick < 90) begin
            // line noise and NOPs
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(1))
                  line_byte(8'($urandom_range(255)));
               else
                  pass_nop();
            end
         end else begin
            // start followed by garbage, biased toward sync bytes
            begin_access(1'($urandom_range(1)), 2'($urandom_range(3)), 8'($urandom_range(255)),
                         16'($urandom_range(65535)), wv);
            repeat ($urandom_range(1, 10))
               line_byte(($urandom_range(99) < 30) ? SYNC_BYTE : 8'($urandom_range(255)));
         end
      end
      steady_send = 1'b0;

      // ---- drain ----
      req_ch.valid <= 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d accesses, %0d line bytes, %0d completion reports checked",
               starts_sent, line_bytes_sent, reports_checked);
      $display("report status codes reached (bit per code, ok at bit 0): %b", status_seen);
      if (mismatch_count == 0 && due_count == 0) begin
         $display("serial_register_access_engine verification clean");
      end else begin
         $display("%0d mismatches, %0d results still due", mismatch_count, due_count);
         $display("serial_register_access_engine verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/sra_pkg.sv
design/sra_channels.sv
design/sra_rx_parser.sv
design/serial_register_access_engine.sv
sim/sra_checker.sv
sim/testbench.sv
